[rtl/core/stv_pkg.sv]
// Shared types and constants for the swept-tone voice.
// Holds the controller-to-datapath command and status structs, the
// configuration struct, register indexes and fixed widths. No dependencies.
package stv_pkg;

    localparam int SAMPLE_RATE  = 22050;
    localparam int ATTACK_RESET = (65536 + SAMPLE_RATE / 400) / (SAMPLE_RATE / 200);

    localparam int SAMPLE_W    = 16;
    localparam int STEP_W      = 32;
    localparam int LEVEL_W     = 16;
    localparam int ATTACK_W    = 17;
    localparam int LEN_W       = 20;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [ATTACK_W-1:0] ATTACK_MAX     = ATTACK_W'(65536);
    localparam logic [ATTACK_W-1:0] ATTACK_RESET_V = ATTACK_W'(ATTACK_RESET);
    localparam logic [LEVEL_W-1:0]  LEVEL_FULL     = '1;

    localparam longint unsigned Q30_ONE     = 64'd1 << 30;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    localparam logic [1:0] WAVE_SINE     = 2'd0;
    localparam logic [1:0] WAVE_TRIANGLE = 2'd1;
    localparam logic [1:0] WAVE_SAW      = 2'd2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_WAVE_MODE        = 3'd0,
        REG_START_PHASE_STEP = 3'd1,
        REG_SWEEP_STEP       = 3'd2,
        REG_AMPLITUDE        = 3'd3,
        REG_DECAY_FACTOR     = 3'd4,
        REG_ATTACK_STEP      = 3'd5,
        REG_TONE_LENGTH      = 3'd6
    } stv_reg_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_CHECK,
        OP_INDEX,
        OP_ROM,
        OP_WAVE,
        OP_ENV,
        OP_AMP,
        OP_TONE,
        OP_SUM,
        OP_UPDATE,
        OP_OUTPUT
    } stv_op_t;

    typedef struct packed {
        stv_op_t op;
    } stv_cmd_t;

    typedef struct packed {
        logic active;
    } stv_status_t;

    typedef struct packed {
        logic [1:0]          wave_mode;
        logic [STEP_W-1:0]   start_phase_step;
        logic [STEP_W-1:0]   sweep_step;        // two's complement
        logic [LEVEL_W-1:0]  amplitude;
        logic [LEVEL_W-1:0]  decay_factor;
        logic [ATTACK_W-1:0] attack_step;
        logic [LEN_W-1:0]    tone_length;
    } stv_cfg_t;

endpackage

[rtl/core/stv_sine_rom.sv]
// Sine lookup ROM, one period of 32767*sin, registered read.
// Contents are built at elaboration by a quarter-wave Q30 series.
// Depends on stv_pkg.
module stv_sine_rom
    import stv_pkg::*;
#(
    parameter int SINE_ENTRIES = 1024
) (
    input  logic                              aclk,
    input  logic                              rd_en,
    input  logic [$clog2(SINE_ENTRIES)-1:0]   rd_addr,
    output logic signed [SAMPLE_W-1:0]        rd_data
);

    localparam longint unsigned ENTRIES_L = SINE_ENTRIES;

    function automatic logic signed [SAMPLE_W-1:0] rom_sine(input longint unsigned j);
        longint unsigned quad;
        longint unsigned rem;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned mag;
        longint          c;
        logic signed [SAMPLE_W-1:0] val;
        quad = (j * 64'd4) / ENTRIES_L;
        rem  = (j * 64'd4) % ENTRIES_L;
        x    = (rem * HALF_PI_Q30) / ENTRIES_L;
        x2   = (x * x) >> 30;
        if (quad[0] == 1'b0) begin
            t   = Q30_ONE - x2 / 64'd110;
            t   = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
            t   = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
            t   = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
            t   = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
            mag = (x * t) >> 30;
            if (mag > Q30_ONE) begin
                mag = Q30_ONE;
            end
        end else begin
            t = Q30_ONE - x2 / 64'd132;
            t = Q30_ONE - ((x2 * t) >> 30) / 64'd90;
            t = Q30_ONE - ((x2 * t) >> 30) / 64'd56;
            t = Q30_ONE - ((x2 * t) >> 30) / 64'd30;
            t = Q30_ONE - ((x2 * t) >> 30) / 64'd12;
            c = longint'(Q30_ONE) - longint'(((x2 * t) >> 30) / 64'd2);
            if (c < 0) begin
                c = 0;
            end
            mag = 64'(c);
        end
        mag = (mag * 64'd32767 + (64'd1 << 29)) >> 30;
        val = SAMPLE_W'(mag);
        if (quad >= 64'd2) begin
            val = -val;
        end
        return val;
    endfunction

    logic signed [SAMPLE_W-1:0] rom_mem [SINE_ENTRIES];
    logic signed [SAMPLE_W-1:0] data_reg;

    for (genvar gi = 0; gi < SINE_ENTRIES; gi++) begin : g_rom
        localparam logic signed [SAMPLE_W-1:0] ROM_VAL = rom_sine(64'(gi));
        assign rom_mem[gi] = ROM_VAL;
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            data_reg <= rom_mem[rd_addr];
        end
    end

    assign rd_data = data_reg;

endmodule

[rtl/core/stv_ctrl.sv]
// Sequencing controller for the swept-tone voice.
// Steps the datapath through one sample and runs both stream handshakes.
// Depends on stv_pkg.
module stv_ctrl
    import stv_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  stv_status_t status,
    output stv_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_INDEX,
        S_ROM,
        S_WAVE,
        S_ENV,
        S_AMP,
        S_TONE,
        S_SUM,
        S_UPDATE,
        S_OUTPUT
    } state_t;

    state_t state_reg;
    logic   s_tready_reg;
    logic   m_tvalid_reg;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        cmd.op = OP_NONE;
        case (state_reg)
            S_IDLE:   cmd.op = (s_tvalid && s_tready_reg) ? OP_LOAD : OP_NONE;
            S_CHECK:  cmd.op = OP_CHECK;
            S_INDEX:  cmd.op = OP_INDEX;
            S_ROM:    cmd.op = OP_ROM;
            S_WAVE:   cmd.op = OP_WAVE;
            S_ENV:    cmd.op = OP_ENV;
            S_AMP:    cmd.op = OP_AMP;
            S_TONE:   cmd.op = OP_TONE;
            S_SUM:    cmd.op = OP_SUM;
            S_UPDATE: cmd.op = OP_UPDATE;
            S_OUTPUT: cmd.op = out_free ? OP_OUTPUT : OP_NONE;
            default:  cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            s_tready_reg <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (state_reg == S_OUTPUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid && s_tready_reg) begin
                        s_tready_reg <= 1'b0;
                        state_reg    <= S_CHECK;
                    end
                end
                S_CHECK:  state_reg <= status.active ? S_INDEX : S_OUTPUT;
                S_INDEX:  state_reg <= S_ROM;
                S_ROM:    state_reg <= S_WAVE;
                S_WAVE:   state_reg <= S_ENV;
                S_ENV:    state_reg <= S_AMP;
                S_AMP:    state_reg <= S_TONE;
                S_TONE:   state_reg <= S_SUM;
                S_SUM:    state_reg <= S_UPDATE;
                S_UPDATE: state_reg <= S_OUTPUT;
                S_OUTPUT: begin
                    if (out_free) begin
                        s_tready_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = s_tready_reg;
    assign m_tvalid = m_tvalid_reg;

endmodule

[rtl/core/stv_datapath.sv]
// Datapath of the swept-tone voice: voice state, wave generation,
// envelope, gain, mix and saturation around one shared 32x32 multiplier.
// Depends on stv_pkg and stv_sine_rom.
module stv_datapath
    import stv_pkg::*;
#(
    parameter int PHASE_BITS   = 32,
    parameter int SINE_ENTRIES = 1024
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  stv_cmd_t                   cmd,
    output stv_status_t                status,
    input  stv_cfg_t                   cfg,
    input  logic signed [SAMPLE_W-1:0] mix_in,
    input  logic                       retrigger,
    output logic signed [SAMPLE_W-1:0] sample_out,
    output logic                       clipped,
    output logic                       tone_active
);

    localparam int IDX_W = $clog2(SINE_ENTRIES);

    // voice state
    logic [PHASE_BITS-1:0] phase_acc_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [ATTACK_W-1:0]   attack_reg;
    logic [LEVEL_W-1:0]    decay_reg;
    logic [LEN_W-1:0]      count_reg;

    // per-sample working registers
    logic signed [SAMPLE_W-1:0] mix_reg;
    logic                       active_reg;
    logic [63:0]                prod_reg;
    logic                       wneg_reg;
    logic [SAMPLE_W-2:0]        vmag_reg;
    logic                       vneg_reg;
    logic [LEVEL_W-1:0]         env_reg;
    logic signed [SAMPLE_W-1:0] sum_reg;
    logic                       clip_reg;

    logic signed [SAMPLE_W-1:0] out_sample_reg;
    logic                       out_clip_reg;
    logic                       out_active_reg;

    logic [31:0]                p32;
    logic [32:0]                tri_mag;
    logic                       tri_neg;
    logic [32:0]                saw_mag;
    logic                       saw_neg;
    logic [31:0]                mul_a;
    logic [31:0]                mul_b;
    logic [63:0]                mul_p;
    logic signed [SAMPLE_W-1:0] rom_q;
    logic [SAMPLE_W-1:0]        rom_abs;
    logic [SAMPLE_W-1:0]        tone;
    logic [SAMPLE_W:0]          sum_wide;
    logic [ATTACK_W:0]          attack_sum;
    logic signed [STEP_W+1:0]   step_sum;
    logic                       is_sine;

    assign status.active = count_reg < cfg.tone_length;

    assign p32     = 32'(phase_acc_reg) << (32 - PHASE_BITS);
    assign is_sine = (cfg.wave_mode != WAVE_TRIANGLE) && (cfg.wave_mode != WAVE_SAW);

    always_comb begin
        tri_neg = 1'b0;
        if (p32 < 32'h4000_0000) begin
            tri_mag = {1'b0, p32};
        end else if (p32 < 32'hC000_0000) begin
            if (p32 <= 32'h8000_0000) begin
                tri_mag = 33'h0_8000_0000 - {1'b0, p32};
            end else begin
                tri_mag = {1'b0, p32} - 33'h0_8000_0000;
                tri_neg = 1'b1;
            end
        end else begin
            tri_mag = 33'h1_0000_0000 - {1'b0, p32};
            tri_neg = 1'b1;
        end
    end

    always_comb begin
        if (p32[31]) begin
            saw_mag = {2'b00, p32[30:0]};
            saw_neg = 1'b0;
        end else begin
            saw_mag = 33'h0_8000_0000 - {1'b0, p32};
            saw_neg = 1'b1;
        end
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_INDEX: begin
                if (cfg.wave_mode == WAVE_TRIANGLE) begin
                    mul_a = tri_mag[31:0];
                    mul_b = 32'd32767;
                end else if (cfg.wave_mode == WAVE_SAW) begin
                    mul_a = saw_mag[31:0];
                    mul_b = 32'd32767;
                end else begin
                    mul_a = p32;
                    mul_b = 32'(SINE_ENTRIES);
                end
            end
            OP_ENV: begin
                mul_a = 32'(attack_reg);
                mul_b = 32'(decay_reg);
            end
            OP_AMP: begin
                mul_a = 32'(vmag_reg);
                mul_b = 32'(cfg.amplitude);
            end
            OP_TONE: begin
                mul_a = 32'(prod_reg[30:0]);
                mul_b = 32'(env_reg);
            end
            OP_SUM: begin
                mul_a = 32'(decay_reg);
                mul_b = 32'(cfg.decay_factor);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = 64'(mul_a) * 64'(mul_b);

    stv_sine_rom #(
        .SINE_ENTRIES(SINE_ENTRIES)
    ) u_rom (
        .aclk    (aclk),
        .rd_en   (cmd.op == OP_ROM),
        .rd_addr (prod_reg[32 +: IDX_W]),
        .rd_data (rom_q)
    );

    assign rom_abs = rom_q[SAMPLE_W-1] ? SAMPLE_W'(-rom_q) : SAMPLE_W'(rom_q);

    assign tone     = vneg_reg ? -{1'b0, prod_reg[46:32]} : {1'b0, prod_reg[46:32]};
    assign sum_wide = {mix_reg[SAMPLE_W-1], mix_reg} + {tone[SAMPLE_W-1], tone};

    assign attack_sum = {1'b0, attack_reg} + {1'b0, cfg.attack_step};
    assign step_sum   = $signed({2'b00, step_reg})
                      + $signed({{2{cfg.sweep_step[STEP_W-1]}}, cfg.sweep_step});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_acc_reg <= '0;
            step_reg      <= '0;
            attack_reg    <= '0;
            decay_reg     <= LEVEL_FULL;
            count_reg     <= '0;
        end else begin
            case (cmd.op)
                OP_LOAD: begin
                    if (retrigger) begin
                        phase_acc_reg <= '0;
                        step_reg      <= cfg.start_phase_step;
                        attack_reg    <= '0;
                        decay_reg     <= LEVEL_FULL;
                        count_reg     <= '0;
                    end
                end
                OP_CHECK: begin
                    if (status.active) begin
                        phase_acc_reg <= phase_acc_reg + step_reg[STEP_W-1 -: PHASE_BITS];
                    end
                end
                OP_UPDATE: begin
                    decay_reg <= prod_reg[31:16];
                    if (attack_sum > {1'b0, ATTACK_MAX}) begin
                        attack_reg <= ATTACK_MAX;
                    end else begin
                        attack_reg <= attack_sum[ATTACK_W-1:0];
                    end
                    if (step_sum[STEP_W+1]) begin
                        step_reg <= '0;
                    end else if (step_sum[STEP_W]) begin
                        step_reg <= '1;
                    end else begin
                        step_reg <= step_sum[STEP_W-1:0];
                    end
                    count_reg <= count_reg + LEN_W'(1);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD:  mix_reg    <= mix_in;
            OP_CHECK: active_reg <= status.active;
            OP_INDEX: begin
                prod_reg <= mul_p;
                wneg_reg <= (cfg.wave_mode == WAVE_TRIANGLE) ? tri_neg : saw_neg;
            end
            OP_WAVE: begin
                if (is_sine) begin
                    vmag_reg <= rom_abs[SAMPLE_W-2:0];
                    vneg_reg <= rom_q[SAMPLE_W-1];
                end else if (cfg.wave_mode == WAVE_TRIANGLE) begin
                    vmag_reg <= prod_reg[44:30];
                    vneg_reg <= wneg_reg;
                end else begin
                    vmag_reg <= prod_reg[45:31];
                    vneg_reg <= wneg_reg;
                end
            end
            OP_ENV: prod_reg <= mul_p;
            OP_AMP: begin
                env_reg  <= prod_reg[31:16];
                prod_reg <= mul_p;
            end
            OP_TONE: prod_reg <= mul_p;
            OP_SUM: begin
                prod_reg <= mul_p;
                if (!sum_wide[SAMPLE_W] && sum_wide[SAMPLE_W-1]) begin
                    sum_reg  <= 16'sh7FFF;
                    clip_reg <= 1'b1;
                end else if (sum_wide[SAMPLE_W] && !sum_wide[SAMPLE_W-1]) begin
                    sum_reg  <= -16'sh8000;
                    clip_reg <= 1'b1;
                end else begin
                    sum_reg  <= $signed(sum_wide[SAMPLE_W-1:0]);
                    clip_reg <= 1'b0;
                end
            end
            OP_OUTPUT: begin
                out_sample_reg <= active_reg ? sum_reg : mix_reg;
                out_clip_reg   <= active_reg && clip_reg;
                out_active_reg <= active_reg;
            end
            default: begin
            end
        endcase
    end

    assign sample_out  = out_sample_reg;
    assign clipped     = out_clip_reg;
    assign tone_active = out_active_reg;

endmodule

[rtl/core/swept_tone_voice.sv]
// Swept-tone synthesizer voice: one input transaction (mix sample plus a
// retrigger flag in tuser) yields one output transaction (mix plus tone,
// saturated, with clip and active flags in tuser). A sounding sample runs the
// check, index, ROM, wave, env, amp, tone, sum, update and output states, a
// pass-through one only check and output; the single shared 32x32 multiplier,
// used five times per sample, and the registered sine ROM read set this. A
// finished result waits in the output register while the next transaction is
// accepted; the voice stalls only when that register is still full at the end
// of the next sample. The configuration port is always ready; write it only
// while the voice is idle. The phase uses PHASE_BITS bits and the sine ROM
// holds SINE_ENTRIES points. Depends on stv_pkg, stv_ctrl and stv_datapath.
module swept_tone_voice
    import stv_pkg::*;
#(
    parameter int PHASE_BITS   = 32,
    parameter int SINE_ENTRIES = 1024
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [SAMPLE_W-1:0]    s_tdata,   // [15:0] mix_in
    input  logic [0:0]             s_tuser,   // [0] retrigger

    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [SAMPLE_W-1:0]    m_tdata,   // [15:0] sample_out
    output logic [1:0]             m_tuser    // [0] clipped, [1] tone_active
);

    stv_cfg_t    cfg_reg;
    stv_cmd_t    cmd;
    stv_status_t status;

    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       clipped;
    logic                       tone_active;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.wave_mode        <= WAVE_SINE;
            cfg_reg.start_phase_step <= '0;
            cfg_reg.sweep_step       <= '0;
            cfg_reg.amplitude        <= '0;
            cfg_reg.decay_factor     <= LEVEL_FULL;
            cfg_reg.attack_step      <= ATTACK_RESET_V;
            cfg_reg.tone_length      <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_WAVE_MODE:        cfg_reg.wave_mode        <= cfg_data[1:0];
                REG_START_PHASE_STEP: cfg_reg.start_phase_step <= cfg_data[STEP_W-1:0];
                REG_SWEEP_STEP:       cfg_reg.sweep_step       <= cfg_data[STEP_W-1:0];
                REG_AMPLITUDE:        cfg_reg.amplitude        <= cfg_data[LEVEL_W-1:0];
                REG_DECAY_FACTOR:     cfg_reg.decay_factor     <= cfg_data[LEVEL_W-1:0];
                REG_ATTACK_STEP:      cfg_reg.attack_step      <= cfg_data[ATTACK_W-1:0];
                REG_TONE_LENGTH:      cfg_reg.tone_length      <= cfg_data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    stv_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    stv_datapath #(
        .PHASE_BITS   (PHASE_BITS),
        .SINE_ENTRIES (SINE_ENTRIES)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .cfg         (cfg_reg),
        .mix_in      ($signed(s_tdata)),
        .retrigger   (s_tuser[0]),
        .sample_out  (sample_out),
        .clipped     (clipped),
        .tone_active (tone_active)
    );

    assign m_tdata = sample_out;
    assign m_tuser = {tone_active, clipped};

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("voice accepted a second transaction while busy");

    a_pass_no_clip: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[1] |-> !m_tuser[0])
        else $error("pass-through sample flagged as clipped");

    a_clip_at_rail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> (m_tdata == 16'h7FFF || m_tdata == 16'h8000))
        else $error("clipped sample not at a rail");

endmodule

[dv/tb_swept_tone_voice.sv]
// Self-checking testbench for swept_tone_voice: drives mix samples with retrigger
// flags, programs the voice registers between runs and checks every output transaction
// against an in-bench model of the voice. Depends on stv_pkg and swept_tone_voice.
module tb_swept_tone_voice;
    import stv_pkg::*;

    localparam int SINE_POINTS = 1024;
    localparam int SETTLE_CYCLES = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                clipped;
        logic                active;
    } voice_out_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [SAMPLE_W-1:0]    s_tdata;   // [15:0] mix_in
    logic [0:0]             s_tuser;   // [0] retrigger
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [SAMPLE_W-1:0]    m_tdata;   // [15:0] sample_out
    logic [1:0]             m_tuser;   // [0] clipped, [1] tone_active

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    stv_cfg_t            cur_cfg;
    logic [31:0]         tone_phase;
    logic [STEP_W-1:0]   tone_step;
    logic [ATTACK_W-1:0] tone_attack;
    logic [LEVEL_W-1:0]  tone_decay;
    logic [LEN_W-1:0]    tone_count;
    int                  sine_rom [SINE_POINTS];

    voice_out_t expected_q [$];
    int fail_count      = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int sounding_seen   = 0;
    int clips_seen      = 0;
    int cfg_writes      = 0;

    swept_tone_voice dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int sine_point(int unsigned j);
        longint unsigned jj, quad, rem, x, x2, t, mag;
        longint c;
        jj = j;
        quad = (jj * 4) / SINE_POINTS;
        rem = (jj * 4) % SINE_POINTS;
        x = (rem * HALF_PI_Q30) / SINE_POINTS;
        x2 = (x * x) >> 30;
        if (quad % 2 == 0) begin
            t = Q30_ONE - x2 / 110;
            t = Q30_ONE - ((x2 * t) >> 30) / 72;
            t = Q30_ONE - ((x2 * t) >> 30) / 42;
            t = Q30_ONE - ((x2 * t) >> 30) / 20;
            t = Q30_ONE - ((x2 * t) >> 30) / 6;
            mag = (x * t) >> 30;
            if (mag > Q30_ONE) mag = Q30_ONE;
        end else begin
            t = Q30_ONE - x2 / 132;
            t = Q30_ONE - ((x2 * t) >> 30) / 90;
            t = Q30_ONE - ((x2 * t) >> 30) / 56;
            t = Q30_ONE - ((x2 * t) >> 30) / 30;
            t = Q30_ONE - ((x2 * t) >> 30) / 12;
            c = longint'(Q30_ONE) - longint'(((x2 * t) >> 30) / 2);
            if (c < 0) c = 0;
            mag = c;
        end
        mag = (mag * 32767 + (64'd1 << 29)) >> 30;
        return (quad >= 2) ? -int'(mag) : int'(mag);
    endfunction

    function automatic int wave_sample(logic [31:0] p);
        longint pp, w;
        longint unsigned m;
        pp = p;
        if (cur_cfg.wave_mode == WAVE_TRIANGLE) begin
            if (p < 32'h4000_0000) w = pp;
            else if (p < 32'hC000_0000) w = 64'sh8000_0000 - pp;
            else w = pp - 64'sh1_0000_0000;
            m = (w < 0) ? -w : w;
            m = (m * 32767) >> 30;
            return (w < 0) ? -int'(m) : int'(m);
        end
        if (cur_cfg.wave_mode == WAVE_SAW) begin
            w = pp - 64'sh8000_0000;
            m = (w < 0) ? -w : w;
            m = (m * 32767) >> 31;
            return (w < 0) ? -int'(m) : int'(m);
        end
        return sine_rom[p[31:22]];
    endfunction

    function automatic voice_out_t predict_sample(logic [SAMPLE_W-1:0] mix_bits, logic retrig);
        voice_out_t r;
        int mix, v, tone, sum;
        longint unsigned a64, d64, env, mag;
        longint next_step, sw;
        int unsigned next_attack;
        mix = $signed(mix_bits);
        if (retrig) begin
            tone_phase  = '0;
            tone_step   = cur_cfg.start_phase_step;
            tone_attack = '0;
            tone_decay  = LEVEL_FULL;
            tone_count  = '0;
        end
        if (tone_count >= cur_cfg.tone_length) begin
            r.sample  = mix_bits;
            r.clipped = 1'b0;
            r.active  = 1'b0;
            return r;
        end
        tone_phase = tone_phase + tone_step;
        v = wave_sample(tone_phase);
        a64 = tone_attack;
        d64 = tone_decay;
        env = (a64 * d64) >> 16;
        mag = (v < 0) ? -v : v;
        mag = mag * cur_cfg.amplitude;
        mag = (mag * env) >> 32;
        tone = (v < 0) ? -int'(mag) : int'(mag);
        sum = mix + tone;
        r.clipped = 1'b0;
        if (sum > 32767) begin
            sum = 32767;
            r.clipped = 1'b1;
        end
        if (sum < -32768) begin
            sum = -32768;
            r.clipped = 1'b1;
        end
        r.sample = 16'(sum);
        r.active = 1'b1;

        next_attack = tone_attack + cur_cfg.attack_step;
        if (next_attack > 65536) next_attack = 65536;
        tone_attack = ATTACK_W'(next_attack);
        tone_decay = LEVEL_W'((d64 * cur_cfg.decay_factor) >> 16);
        sw = $signed(cur_cfg.sweep_step);
        next_step = tone_step;
        next_step = next_step + sw;
        if (next_step < 0) next_step = 0;
        if (next_step > 64'sh0_FFFF_FFFF) next_step = 64'sh0_FFFF_FFFF;
        tone_step = next_step[31:0];
        tone_count = tone_count + 1'b1;
        return r;
    endfunction

    task automatic note_failure(string what);
        fail_count++;
        if (fail_count <= 10) $display("mismatch: %s", what);
    endtask

    always @(posedge aclk) m_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge aclk) begin : check_results
        voice_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_q.size() == 0) begin
                note_failure($sformatf("unexpected result sample %h tuser %b", m_tdata, m_tuser));
            end else begin
                want = expected_q.pop_front();
                results_checked++;
                if (want.active) sounding_seen++;
                if (want.clipped) clips_seen++;
                if (m_tdata !== want.sample || m_tuser[0] !== want.clipped ||
                    m_tuser[1] !== want.active) begin
                    note_failure($sformatf(
                        "result %0d: sample %h clip %b active %b, expected %h %b %b",
                        results_checked, m_tdata, m_tuser[0], m_tuser[1],
                        want.sample, want.clipped, want.active));
                end
            end
        end
    end

    task automatic send_sample(logic [SAMPLE_W-1:0] mix, logic retrig);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= mix;
        s_tuser  <= retrig;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_q.push_back(predict_sample(mix, retrig));
        items_sent++;
    endtask

    task automatic drain_voice();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_writes++;
        case (idx)
            REG_WAVE_MODE:        cur_cfg.wave_mode        = data[1:0];
            REG_START_PHASE_STEP: cur_cfg.start_phase_step = data;
            REG_SWEEP_STEP:       cur_cfg.sweep_step       = data;
            REG_AMPLITUDE:        cur_cfg.amplitude        = data[LEVEL_W-1:0];
            REG_DECAY_FACTOR:     cur_cfg.decay_factor     = data[LEVEL_W-1:0];
            REG_ATTACK_STEP:      cur_cfg.attack_step      = data[ATTACK_W-1:0];
            REG_TONE_LENGTH:      cur_cfg.tone_length      = data[LEN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic cfg_release();
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [31:0] pad_field(logic [31:0] v, int w);
        logic [31:0] junk;
        junk = $urandom_range(1) ? $urandom() : 32'd0;
        if (w >= 32) return v;
        return v | (junk << w);
    endfunction

    task automatic program_voice(stv_cfg_t c);
        drain_voice();
        write_reg(REG_WAVE_MODE, pad_field(c.wave_mode, 2));
        write_reg(REG_START_PHASE_STEP, c.start_phase_step);
        write_reg(REG_SWEEP_STEP, c.sweep_step);
        write_reg(REG_AMPLITUDE, pad_field(c.amplitude, LEVEL_W));
        write_reg(REG_DECAY_FACTOR, pad_field(c.decay_factor, LEVEL_W));
        write_reg(REG_ATTACK_STEP, pad_field(c.attack_step, ATTACK_W));
        write_reg(REG_TONE_LENGTH, pad_field(c.tone_length, LEN_W));
        cfg_release();
    endtask

    function automatic logic [SAMPLE_W-1:0] random_mix();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic stv_cfg_t random_voice_cfg();
        stv_cfg_t c;
        c.wave_mode = 2'($urandom_range(3));
        case ($urandom_range(9))
            0: c.start_phase_step = '0;
            1: c.start_phase_step = '1;
            2, 3, 4: c.start_phase_step = $urandom();
            default: c.start_phase_step = $urandom_range(32'h0800_0000);
        endcase
        case ($urandom_range(9))
            0: c.sweep_step = 32'h8000_0000;
            1: c.sweep_step = 32'h7FFF_FFFF;
            2: c.sweep_step = '0;
            3: c.sweep_step = $urandom();
            default: c.sweep_step = 32'($urandom_range(2097152)) - 32'd1048576;
        endcase
        case ($urandom_range(7))
            0: c.amplitude = '0;
            1, 2: c.amplitude = '1;
            default: c.amplitude = 16'($urandom_range(65535));
        endcase
        case ($urandom_range(7))
            0: c.decay_factor = '0;
            1: c.decay_factor = '1;
            2: c.decay_factor = 16'($urandom_range(65535));
            default: c.decay_factor = 16'($urandom_range(16'hFFFF, 16'hF000));
        endcase
        case ($urandom_range(7))
            0: c.attack_step = '0;
            1: c.attack_step = ATTACK_MAX;
            2: c.attack_step = '1;
            3: c.attack_step = 17'($urandom_range(17'h1FFFF));
            default: c.attack_step = 17'($urandom_range(17'h4000, 1));
        endcase
        case ($urandom_range(9))
            0: c.tone_length = '0;
            1: c.tone_length = '1;
            default: c.tone_length = 20'($urandom_range(40, 1));
        endcase
        return c;
    endfunction

    task automatic test_reset_passthrough();
        send_sample(16'h8000, 1'b1);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h1234, 1'b1);
    endtask

    task automatic test_wave_shapes();
        stv_cfg_t c;
        for (int m = 0; m < 4; m++) begin
            c = '{wave_mode: 2'(m), start_phase_step: 32'h1234_5678, sweep_step: 32'h0,
                  amplitude: 16'hFFFF, decay_factor: 16'hFFFF, attack_step: 17'h1FFFF,
                  tone_length: 20'd8};
            program_voice(c);
            send_sample(16'h0000, 1'b1);
            send_sample(16'h0000, 1'b0);
        end
    endtask

    task automatic test_clip_limits();
        stv_cfg_t c;
        c = '{wave_mode: WAVE_SAW, start_phase_step: 32'h2000_0000, sweep_step: 32'h0,
              amplitude: 16'hFFFF, decay_factor: 16'hFFFF, attack_step: ATTACK_MAX,
              tone_length: 20'd8};
        program_voice(c);
        send_sample(16'h8000, 1'b1);
        send_sample(16'h8000, 1'b0);
        c.wave_mode = WAVE_TRIANGLE;
        program_voice(c);
        send_sample(16'h7FFF, 1'b1);
        send_sample(16'h7FFF, 1'b0);
    endtask

    task automatic test_step_saturation();
        stv_cfg_t c;
        c = '{wave_mode: WAVE_SINE, start_phase_step: 32'hFFFF_FF00, sweep_step: 32'h7FFF_FFFF,
              amplitude: 16'h8000, decay_factor: 16'hFFFF, attack_step: ATTACK_MAX,
              tone_length: 20'd8};
        program_voice(c);
        send_sample(16'h0001, 1'b1);
        send_sample(16'hFFFF, 1'b0);
        c.start_phase_step = 32'h0000_0100;
        c.sweep_step = 32'h8000_0000;
        program_voice(c);
        send_sample(16'h0001, 1'b1);
        send_sample(16'hFFFF, 1'b0);
    endtask

    task automatic test_length_rewrite();
        stv_cfg_t c;
        c = '{wave_mode: WAVE_TRIANGLE, start_phase_step: 32'h0400_0000, sweep_step: 32'h10000,
              amplitude: 16'hC000, decay_factor: 16'hFF00, attack_step: 17'd20000,
              tone_length: 20'd2};
        program_voice(c);
        send_sample(16'h0100, 1'b1);
        send_sample(16'h0100, 1'b0);
        send_sample(16'h0100, 1'b0);
        drain_voice();
        write_reg(REG_UNUSED, $urandom());
        write_reg(REG_TONE_LENGTH, 32'd4);
        cfg_release();
        send_sample(16'hFF00, 1'b0);
        send_sample(16'hFF00, 1'b0);
    endtask

    task automatic test_random_traffic(int idle_pct, int stall_pct, int item_count);
        int target;
        int burst;
        int cut;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        target = items_sent + item_count;
        while (items_sent < target) begin
            program_voice(random_voice_cfg());
            burst = $urandom_range(40, 10);
            if (burst > target - items_sent) burst = target - items_sent;
            cut = ($urandom_range(3) == 0) ? $urandom_range(burst - 1, 1) : -1;
            for (int k = 0; k < burst; k++) begin
                if (k == cut) begin
                    drain_voice();
                    write_reg(REG_TONE_LENGTH, pad_field($urandom_range(60), LEN_W));
                    cfg_release();
                end
                if (k == 0) send_sample(random_mix(), $urandom_range(99) < 85);
                else send_sample(random_mix(), $urandom_range(99) < 4);
            end
        end
        drain_voice();
    endtask

    initial begin
        int waited;
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cur_cfg = '{wave_mode: WAVE_SINE, start_phase_step: '0, sweep_step: '0,
                    amplitude: '0, decay_factor: LEVEL_FULL, attack_step: ATTACK_RESET_V,
                    tone_length: '0};
        tone_phase  = '0;
        tone_step   = '0;
        tone_attack = '0;
        tone_decay  = LEVEL_FULL;
        tone_count  = cur_cfg.tone_length;
        for (int j = 0; j < SINE_POINTS; j++) sine_rom[j] = sine_point(j);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_passthrough();
        test_wave_shapes();
        test_clip_limits();
        test_step_saturation();
        test_length_rewrite();
        test_random_traffic(0, 0, 138);
        test_random_traffic(76, 0, 138);
        test_random_traffic(0, 76, 138);
        test_random_traffic(22, 22, 138);

        s_tvalid <= 1'b0;
        waited = 0;
        while (expected_q.size() != 0 && waited < 50000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (expected_q.size() != 0) begin
            note_failure($sformatf("%0d results never arrived", expected_q.size()));
            fail_count += expected_q.size() - 1;
        end

        $display("covered %0d samples (%0d sounding, %0d clipped) across %0d register writes,",
                 items_sent, sounding_seen, clips_seen, cfg_writes);
        $display("all wave modes, step limits, length rewrites and four pacing phases");
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/stv_pkg.sv
rtl/core/stv_sine_rom.sv
rtl/core/stv_ctrl.sv
rtl/core/stv_datapath.sv
rtl/core/swept_tone_voice.sv
dv/tb_swept_tone_voice.sv
